/* rtl/core/hsta_pkg.sv */
// shared types, codes and constants of the hold-time accumulator
`timescale 1ns / 1ps
`default_nettype none

package hsta_pkg;

    localparam int TIME_WIDTH = 48;
    localparam int NOW_WIDTH  = 48;
    localparam int TIME_MAX_W = 64;
    localparam int REG_WIDTH  = 31;
    localparam int ACC_WIDTH  = 32;
    localparam int CMD_WIDTH  = 2;
    localparam int EV_WIDTH   = 3;

    localparam logic [REG_WIDTH-1:0] DEFAULT_TIMEOUT = REG_WIDTH'(1000);

    // command codes
    localparam logic [CMD_WIDTH-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_RESTART = 2'd2;

    // event codes
    localparam logic [EV_WIDTH-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_WIDTH-1:0] EV_START     = 3'd1;
    localparam logic [EV_WIDTH-1:0] EV_STOP      = 3'd2;
    localparam logic [EV_WIDTH-1:0] EV_CONTINUE  = 3'd3;
    localparam logic [EV_WIDTH-1:0] EV_COMPLETED = 3'd4;

    // register indexes
    localparam logic CFG_IDX_REQUIRED = 1'b0;
    localparam logic CFG_IDX_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic [REG_WIDTH-1:0] required_hold;
        logic [REG_WIDTH-1:0] heartbeat_timeout;
    } cfg_t;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] command;
        logic [NOW_WIDTH-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [EV_WIDTH-1:0]  event_res;
        logic [ACC_WIDTH-1:0] accumulated;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/hsta_cfg.sv */
// configuration registers of the hold-time accumulator
`timescale 1ns / 1ps
`default_nettype none

module hsta_cfg
    import hsta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    logic [REG_WIDTH-1:0] required_reg;
    logic [REG_WIDTH-1:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_reg <= '0;
            timeout_reg  <= DEFAULT_TIMEOUT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_REQUIRED: required_reg <= cfg_data[REG_WIDTH-1:0];
                CFG_IDX_TIMEOUT:  timeout_reg  <= cfg_data[REG_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.required_hold     = required_reg;
    assign cfg.heartbeat_timeout = timeout_reg;

endmodule

`default_nettype wire

/* rtl/core/hsta_in_stage.sv */
// input register stage of the hold-time accumulator
`timescale 1ns / 1ps
`default_nettype none

module hsta_in_stage
    import hsta_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  out_free,
    output logic       fire,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign fire       = valid_reg && out_free;
    assign in_ready   = !valid_reg || fire;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

/* rtl/core/hsta_core.sv */
// hold state and per-item update logic
`timescale 1ns / 1ps
`default_nettype none

module hsta_core
    import hsta_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    logic                  active_reg;
    logic                  active_next;
    logic                  finished_reg;
    logic                  finished_next;
    logic [TIME_WIDTH-1:0] last_reg;
    logic [TIME_WIDTH-1:0] last_next;
    logic [ACC_WIDTH-1:0]  total_reg;
    logic [ACC_WIDTH-1:0]  total_next;
    logic [EV_WIDTH-1:0]   ev;

    logic [TIME_MAX_W-1:0] now_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] diff;
    logic                  forward;
    logic [REG_WIDTH-1:0]  limit;
    logic                  gap_over;
    logic [REG_WIDTH-1:0]  gap;
    logic [ACC_WIDTH:0]    sum;
    logic [ACC_WIDTH-1:0]  sum_sat;
    logic                  disabled;

    assign now_ext  = TIME_MAX_W'(item.now_ms);
    assign now_t    = now_ext[TIME_WIDTH-1:0];
    assign forward  = now_t > last_reg;
    assign diff     = now_t - last_reg;
    assign limit    = (cfg.heartbeat_timeout == '0) ? DEFAULT_TIMEOUT : cfg.heartbeat_timeout;
    assign gap_over = forward && (diff > TIME_WIDTH'(limit));
    // below the limit the gap fits in the register width
    assign gap      = forward ? diff[REG_WIDTH-1:0] : '0;
    assign sum      = {1'b0, total_reg} + (ACC_WIDTH + 1)'(gap);
    assign sum_sat  = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    assign disabled = (cfg.required_hold == '0) || finished_reg;

    always_comb
    begin
        active_next   = active_reg;
        finished_next = finished_reg;
        last_next     = last_reg;
        total_next    = total_reg;
        ev            = EV_NONE;
        case (item.command)
            CMD_TICK:
            begin
                if (!disabled)
                begin
                    last_next = now_t;
                    if (!active_reg)
                    begin
                        active_next = 1'b1;
                        ev          = EV_START;
                    end
                    else if (gap_over)
                    begin
                        active_next = 1'b0;
                        ev          = EV_STOP;
                    end
                    else
                    begin
                        total_next = sum_sat;
                        if (sum_sat >= ACC_WIDTH'(cfg.required_hold))
                        begin
                            finished_next = 1'b1;
                            active_next   = 1'b0;
                            ev            = EV_COMPLETED;
                        end
                        else
                        begin
                            ev = EV_CONTINUE;
                        end
                    end
                end
            end
            CMD_TIMEOUT:
            begin
                if (!disabled && active_reg)
                begin
                    active_next = 1'b0;
                    ev          = EV_STOP;
                end
            end
            CMD_RESTART:
            begin
                active_next   = 1'b0;
                finished_next = 1'b0;
                last_next     = '0;
                total_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            finished_reg <= 1'b0;
            last_reg     <= '0;
            total_reg    <= '0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            finished_reg <= finished_next;
            last_reg     <= last_next;
            total_reg    <= total_next;
        end
    end

    assign result.event_res   = ev;
    assign result.accumulated = total_next;

endmodule

`default_nettype wire

/* rtl/core/hsta_out_stage.sv */
// result register stage of the hold-time accumulator
`timescale 1ns / 1ps
`default_nettype none

module hsta_out_stage
    import hsta_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t in_result,
    output logic         out_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/signal_hold_time_accumulator.sv */
// top level of the signal hold-time accumulator
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: command, tdata: now_ms
//  m_*       out        m_tvalid / m_tready  tuser: event_res, tdata: accumulated
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle while the result is not stalled; each transfer goes through
// the input register, then update logic and the result register
// reset clears the hold state and loads the register defaults
// a stalled result holds the result register; the input register
// refills as soon as the result register frees, in the same cycle
`timescale 1ns / 1ps
`default_nettype none

module signal_hold_time_accumulator
    import hsta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [47:0] now_ms
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] accumulated
    output logic [2:0]       m_tuser,   // [2:0] event_res
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    result_t result;
    result_t out_result;
    logic    out_free;
    logic    fire;

    assign in_item.command = s_tuser;
    assign in_item.now_ms  = s_tdata;

    hsta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsta_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    hsta_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    hsta_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .in_result  (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = out_result.accumulated;
    assign m_tuser = out_result.event_res;

endmodule

`default_nettype wire
